[hdl/rwsd_pkg.sv]
// Shared widths and reset constants for the rolling window deviation block.
package rwsd_pkg;

    // Configuration register width, reset value and default largest window.
    localparam int LEN_W          = 9;
    localparam int WL_RESET       = 20;
    localparam int MAX_WINDOW_DEF = 256;

    // Payload field widths.
    localparam int DATE_W  = 22;
    localparam int VALUE_W = 24;
    localparam int STD_W   = 24;

    // Stream data widths, packed fields padded to whole bytes.
    localparam int S_DATA_W = ((DATE_W + VALUE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((DATE_W + STD_W + 7) / 8) * 8;

    // Accumulator and arithmetic unit widths.
    localparam int SUM_W   = 32;
    localparam int SUMSQ_W = 56;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ROOT_W  = PROD_W / 2;
    localparam int ITER_W  = $clog2(ROOT_W);

    typedef logic [MUL_W-1:0]  mul_op_t;
    typedef logic [PROD_W-1:0] prod_t;

endpackage

[hdl/rolling_window_std_deviation_top.sv]
// Rolling window population standard deviation with a shared multiplier and bit-serial units.
// A sample that completes the window passes through the update and multiply states, the
// difference, the square root steps, the divide steps and the output load, in that order.
// s_tready is high only in the idle state: a new sample is taken only after the last one is done,
// including any wait for the receiver. The square root and divide loops give one bit per cycle.
// Reset (aresetn low, synchronous): window length returns to 20; fill count, sums, write
// pointer and output valid clear. The sample ring is not cleared and needs no clearing pass.
module rolling_window_std_deviation_top #(
    parameter int MAX_WINDOW = rwsd_pkg::MAX_WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: window length.
    input  logic                          cfg_wr_en,
    input  logic [rwsd_pkg::LEN_W-1:0]    cfg_wr_data,
    // Input samples.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rwsd_pkg::S_DATA_W-1:0] s_tdata,   // sample_date, sample_value, zero pad
    input  logic                          s_tuser,   // series_start
    // Results.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rwsd_pkg::M_DATA_W-1:0] m_tdata    // result_date, std_deviation, zero pad
);
    import rwsd_pkg::*;

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int ADDR_W = LEN_W + 1;

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OLD   = 4'd1;
    localparam logic [3:0] S_SUBSQ = 4'd2;
    localparam logic [3:0] S_ADDSQ = 4'd3;
    localparam logic [3:0] S_MLO   = 4'd4;
    localparam logic [3:0] S_MHI   = 4'd5;
    localparam logic [3:0] S_SQS   = 4'd6;
    localparam logic [3:0] S_DIFF  = 4'd7;
    localparam logic [3:0] S_SQRT  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]          state_reg;
    logic [LEN_W-1:0]    wl_reg;
    logic [PTR_W-1:0]    wp_reg;
    logic [LEN_W-1:0]    fill_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUMSQ_W-1:0]  sumsq_reg;
    logic [DATE_W-1:0]   date_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [VALUE_W-1:0]  old_reg;
    logic [VALUE_W-1:0]  ring [MAX_WINDOW];
    prod_t               prod_reg;
    prod_t               acc_reg;
    prod_t               rad_reg;
    logic [ROOT_W+2:0]   sq_rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [LEN_W-1:0]    div_rem_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [LEN_W-1:0]    n_eff;
    logic [ADDR_W-1:0]   wp_ext;
    logic [ADDR_W-1:0]   n_ext;
    logic [PTR_W-1:0]    oldest_addr;
    logic                s_accept;
    logic                window_full;
    logic [LEN_W-1:0]    fill_inc;
    logic                out_load;
    mul_op_t             mul_a;
    mul_op_t             mul_b;
    prod_t               mul_p;
    logic [ROOT_W+2:0]   sq_shift;
    logic [ROOT_W+2:0]   sq_trial;
    logic                sq_fit;
    logic [LEN_W-1:0]    div_shift;
    logic                div_fit;

    // Effective window length: zero acts as one, large values saturate.
    always_comb begin
        n_eff = wl_reg;
        if (wl_reg == '0) begin
            n_eff = LEN_W'(1);
        end else if (wl_reg > LEN_W'(MAX_WINDOW)) begin
            n_eff = LEN_W'(MAX_WINDOW);
        end
    end

    // Ring address of the sample that leaves the window.
    assign wp_ext = ADDR_W'(wp_reg);
    assign n_ext  = ADDR_W'(n_eff);
    always_comb begin
        if (wp_ext >= n_ext) begin
            oldest_addr = PTR_W'(wp_ext - n_ext);
        end else begin
            oldest_addr = PTR_W'(wp_ext + ADDR_W'(MAX_WINDOW) - n_ext);
        end
    end

    assign s_tready    = (state_reg == S_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign window_full = (fill_reg >= n_eff);
    assign fill_inc    = fill_reg + LEN_W'(1);
    assign out_load    = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_OLD: begin
                mul_a = MUL_W'(old_reg);
                mul_b = MUL_W'(old_reg);
            end
            S_SUBSQ: begin
                mul_a = MUL_W'(value_reg);
                mul_b = MUL_W'(value_reg);
            end
            S_MLO: begin
                mul_a = MUL_W'(n_eff);
                mul_b = sumsq_reg[MUL_W-1:0];
            end
            S_MHI: begin
                mul_a = MUL_W'(n_eff);
                mul_b = MUL_W'(sumsq_reg[SUMSQ_W-1:MUL_W]);
            end
            S_SQS: begin
                mul_a = MUL_W'(sum_reg);
                mul_b = MUL_W'(sum_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // One square root step: bring down two radicand bits and try root*4+1.
    assign sq_shift = {sq_rem_reg[ROOT_W:0], rad_reg[PROD_W-1:PROD_W-2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_fit   = (sq_shift >= sq_trial);

    // One restoring divide step by the window length.
    assign div_shift = {div_rem_reg[LEN_W-2:0], root_reg[ROOT_W-1]};
    assign div_fit   = (div_shift >= n_eff);

    // Sample ring: oldest value read at acceptance, new value written in the following cycle.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            old_reg <= ring[oldest_addr];
        end
        if (state_reg == S_OLD) begin
            ring[wp_reg] <= value_reg;
        end
    end

    // Multiplier output register.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
    end

    // Sequencer, accumulators and bit-serial datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wl_reg    <= LEN_W'(WL_RESET);
            wp_reg    <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            iter_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                wl_reg    <= cfg_wr_data;
                fill_reg  <= '0;
                sum_reg   <= '0;
                sumsq_reg <= '0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        date_reg  <= s_tdata[DATE_W-1:0];
                        value_reg <= s_tdata[DATE_W+VALUE_W-1:DATE_W];
                        if (s_tuser) begin
                            fill_reg  <= '0;
                            sum_reg   <= '0;
                            sumsq_reg <= '0;
                        end
                        state_reg <= S_OLD;
                    end
                end
                S_OLD: begin
                    if (window_full) begin
                        sum_reg <= sum_reg - SUM_W'(old_reg);
                    end
                    if (wp_reg == PTR_W'(MAX_WINDOW - 1)) begin
                        wp_reg <= '0;
                    end else begin
                        wp_reg <= wp_reg + PTR_W'(1);
                    end
                    state_reg <= S_SUBSQ;
                end
                S_SUBSQ: begin
                    if (window_full) begin
                        sumsq_reg <= sumsq_reg - SUMSQ_W'(prod_reg);
                    end
                    sum_reg   <= sum_reg + SUM_W'(value_reg);
                    state_reg <= S_ADDSQ;
                end
                S_ADDSQ: begin
                    sumsq_reg <= sumsq_reg + SUMSQ_W'(prod_reg);
                    if (window_full) begin
                        fill_reg  <= n_eff;
                        state_reg <= S_MLO;
                    end else begin
                        fill_reg <= fill_inc;
                        if (fill_inc >= n_eff) begin
                            state_reg <= S_MLO;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_MLO: begin
                    state_reg <= S_MHI;
                end
                S_MHI: begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_SQS;
                end
                S_SQS: begin
                    acc_reg   <= acc_reg + {prod_reg[MUL_W-1:0], {MUL_W{1'b0}}};
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    // N times the sum of squares less the squared sum.
                    if (acc_reg >= prod_reg) begin
                        rad_reg <= acc_reg - prod_reg;
                    end else begin
                        rad_reg <= '0;
                    end
                    sq_rem_reg <= '0;
                    root_reg   <= '0;
                    iter_reg   <= '0;
                    state_reg  <= S_SQRT;
                end
                S_SQRT: begin
                    rad_reg    <= {rad_reg[PROD_W-3:0], 2'b00};
                    sq_rem_reg <= sq_fit ? (sq_shift - sq_trial) : sq_shift;
                    root_reg   <= {root_reg[ROOT_W-2:0], sq_fit};
                    iter_reg   <= iter_reg + ITER_W'(1);
                    if (iter_reg == ITER_W'(ROOT_W - 1)) begin
                        div_rem_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV: begin
                    // The root register shifts out dividend bits and takes quotient bits.
                    div_rem_reg <= div_fit ? (div_shift - n_eff) : div_shift;
                    root_reg    <= {root_reg[ROOT_W-2:0], div_fit};
                    iter_reg    <= iter_reg + ITER_W'(1);
                    if (iter_reg == ITER_W'(ROOT_W - 1)) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= M_DATA_W'({root_reg[STD_W-1:0], date_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    // The fill count never passes the effective window length between items.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (fill_reg <= n_eff))
        else $error("fill count exceeds window length");

    // The variance numerator never goes negative for a consistent window.
    a_numerator: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIFF) |-> (acc_reg >= prod_reg))
        else $error("squared sum exceeds scaled sum of squares");

    // The square root hands over to the divider after its last step.
    a_sqrt_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQRT) && (iter_reg == ITER_W'(ROOT_W - 1)) |=> (state_reg == S_DIV))
        else $error("square root did not hand over to divider");

    // A loaded result is presented on the next cycle.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && (state_reg == S_IDLE))
        else $error("result load did not raise m_tvalid");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the rolling window standard deviation block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rwsd_pkg::*;

    localparam int CLK_HALF_NS     = 2;
    localparam int RESET_CYCLES    = 11;
    // Longer than the longest result latency, to leave slack after the last result.
    localparam int SETTLE_CYCLES   = 90;
    localparam int RX_HOLD_CYCLES  = 500;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int REPORT_LIMIT    = 10;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam logic [DATE_W-1:0]  DATE_MAX  = '1;

    typedef enum logic [0:0] {ROW_SAMPLE, ROW_CFG} row_kind_e;
    // How a directed row is checked: no result, a typed result, or the predictor.
    typedef enum logic [1:0] {CHK_NONE, CHK_GIVEN, CHK_MODEL} check_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [LEN_W-1:0]   len;
        logic               start;
        logic [DATE_W-1:0]  date;
        logic [VALUE_W-1:0] value;
        check_e             chk;
        logic [STD_W-1:0]   dev;
    } stim_row_t;

    typedef struct packed {
        logic [DATE_W-1:0] date;
        logic [STD_W-1:0]  dev;
    } dev_result_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [LEN_W-1:0]    cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // sample_date, sample_value, zero pad
    logic                s_tuser;   // series_start
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // result_date, std_deviation, zero pad

    // Predicted window state.
    logic [LEN_W-1:0]   win_len_reg;
    logic [VALUE_W-1:0] ring [256];
    logic [7:0]         ring_wp;
    logic [LEN_W-1:0]   fill_cnt;
    logic [SUM_W-1:0]   win_sum;
    logic [SUMSQ_W-1:0] win_sumsq;

    dev_result_t pending_devs[$];

    int mismatch_cnt  = 0;
    int samples_sent  = 0;
    int results_seen  = 0;
    int tx_idle_pct   = 9;
    int rx_idle_pct   = 9;
    int rx_hold_req   = 0;
    logic [DATE_W-1:0]  date_cursor = '0;
    logic [VALUE_W-1:0] value_base  = '0;

    // Directed rows: reset window of 20 filled with extremes, then window
    // lengths of one, zero (taken as one) and two, with series restarts.
    // A window of half zeros and half full-scale values has a deviation of
    // half the full scale.
    stim_row_t dir_rows [30] = '{
        '{ROW_SAMPLE, 9'd0, 1'b1, 22'h000000, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h3FFFFF, 24'hFFFFFF, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h155555, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h2AAAAA, 24'hFFFFFF, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000005, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000006, 24'hFFFFFF, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000007, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000008, 24'hFFFFFF, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000009, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h00000A, 24'hFFFFFF, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h00000B, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h00000C, 24'hFFFFFF, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h00000D, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h00000E, 24'hFFFFFF, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h00000F, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000010, 24'hFFFFFF, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000011, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000012, 24'hFFFFFF, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000013, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000014, 24'hFFFFFF, CHK_GIVEN, 24'h7FFFFF},
        '{ROW_CFG,    9'd1, 1'b0, 22'h000000, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h3FFFFF, 24'hFFFFFF, CHK_GIVEN, 24'h0},
        '{ROW_CFG,    9'd0, 1'b0, 22'h000000, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h012345, 24'hABCDEF, CHK_GIVEN, 24'h0},
        '{ROW_CFG,    9'd2, 1'b0, 22'h000000, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b1, 22'h00001E, 24'h000000, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h00001F, 24'hFFFFFF, CHK_GIVEN, 24'h7FFFFF},
        '{ROW_SAMPLE, 9'd0, 1'b1, 22'h000020, 24'hFFFFFF, CHK_NONE,  24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000021, 24'hFFFFFF, CHK_GIVEN, 24'h0},
        '{ROW_SAMPLE, 9'd0, 1'b0, 22'h000022, 24'h123456, CHK_MODEL, 24'h0}
    };

    rolling_window_std_deviation_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Free-running clock.
    always begin
        aclk = 1'b0;
        #CLK_HALF_NS;
        aclk = 1'b1;
        #CLK_HALF_NS;
    end

    // Window state after a length write or the start of a new series.
    function automatic void clear_window_state();
        fill_cnt  = '0;
        win_sum   = '0;
        win_sumsq = '0;
    endfunction

    // Take one sample into the predicted window; returns 1 when a deviation is due.
    function automatic bit step_window(input logic start, input logic [VALUE_W-1:0] value,
                                       output logic [STD_W-1:0] dev);
        logic [LEN_W-1:0]   eff;
        logic [7:0]         oldest;
        logic [VALUE_W-1:0] old_v;
        logic [63:0]        num;
        logic [63:0]        sq;
        logic [63:0]        root;
        logic [63:0]        cand;
        logic [63:0]        quot;
        int                 b;
        eff = (win_len_reg == '0) ? 9'd1 : ((win_len_reg > 9'd256) ? 9'd256 : win_len_reg);
        dev = '0;
        if (start)
            clear_window_state();
        // A full window drops its oldest sample first.
        if (fill_cnt >= eff) begin
            oldest    = ring_wp - eff[7:0];
            old_v     = ring[oldest];
            win_sum   = win_sum - SUM_W'(old_v);
            win_sumsq = win_sumsq - SUMSQ_W'(old_v) * SUMSQ_W'(old_v);
            fill_cnt  = eff;
        end
        ring[ring_wp] = value;
        win_sum       = win_sum + SUM_W'(value);
        win_sumsq     = win_sumsq + SUMSQ_W'(value) * SUMSQ_W'(value);
        ring_wp       = ring_wp + 8'd1;
        if (fill_cnt < eff)
            fill_cnt = fill_cnt + 9'd1;
        if (fill_cnt < eff)
            return 1'b0;
        // N * sum of squares less the squared sum, clamped at zero.
        sq  = 64'(win_sum) * 64'(win_sum);
        num = 64'(eff) * 64'(win_sumsq);
        num = (num >= sq) ? num - sq : 64'd0;
        // Integer square root, one result bit at a time from the top.
        root = '0;
        for (b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= num)
                root = cand;
        end
        quot = root / 64'(eff);
        dev  = quot[STD_W-1:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (mismatch_cnt < REPORT_LIMIT)
            $display("Mismatch in %s: expected %0d, got %0d", what, want, got);
        mismatch_cnt++;
    endtask

    task automatic wait_results_drained();
        while (pending_devs.size() != 0)
            @(posedge aclk);
    endtask

    // Offer one sample, wait for its transfer and record what it should produce.
    task automatic send_sample(input logic start, input logic [DATE_W-1:0] date,
                               input logic [VALUE_W-1:0] value, input check_e chk,
                               input logic [STD_W-1:0] given_dev);
        logic [STD_W-1:0] dev;
        bit               has_dev;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {{(S_DATA_W - DATE_W - VALUE_W){1'b0}}, value, date};
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        has_dev = step_window(start, value, dev);
        case (chk)
            CHK_MODEL: begin
                if (has_dev)
                    pending_devs.push_back('{date: date, dev: dev});
            end
            CHK_GIVEN: pending_devs.push_back('{date: date, dev: given_dev});
            default: ;
        endcase
        samples_sent++;
    endtask

    // Length writes happen only with the block idle.
    task automatic write_window_length(input logic [LEN_W-1:0] len);
        s_tvalid <= 1'b0;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        win_len_reg = len;
        clear_window_state();
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return VALUE_MAX;
            2:       return VALUE_W'($urandom_range(15));
            3, 4, 5: return value_base + VALUE_W'($urandom_range(255));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATE_W-1:0] pick_date();
        if ($urandom_range(9) == 0)
            date_cursor = DATE_W'($urandom);
        else
            date_cursor = date_cursor + DATE_W'(1);
        return date_cursor;
    endfunction

    // One random phase at a given window length; with_pressure adds a long
    // receiver hold-off and a sender pause.
    task automatic run_phase(input logic [LEN_W-1:0] len, input int items,
                             input int start_pct, input bit with_pressure);
        write_window_length(len);
        value_base = VALUE_W'($urandom);
        for (int i = 0; i < items; i++) begin
            if (with_pressure && i == items / 3)
                rx_hold_req <= rx_hold_req + 1;
            if (with_pressure && i == (2 * items) / 3) begin
                s_tvalid <= 1'b0;
                wait_results_drained();
                @(posedge aclk);
            end
            send_sample($urandom_range(99) < start_pct, pick_date(), pick_value(),
                        CHK_MODEL, '0);
        end
    endtask

    // Receiver: random back-pressure, plus long hold-offs on request.
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req != hold_seen) begin
                hold_seen = rx_hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare every result transfer with the oldest pending deviation.
    always @(posedge aclk) begin : result_check
        dev_result_t        want;
        logic [DATE_W-1:0]  got_date;
        logic [STD_W-1:0]   got_dev;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got_date = m_tdata[DATE_W-1:0];
            got_dev  = m_tdata[DATE_W+STD_W-1:DATE_W];
            results_seen++;
            if (pending_devs.size() == 0) begin
                report_mismatch("result with nothing pending, date", -1, got_date);
            end else begin
                want = pending_devs.pop_front();
                if (got_date !== want.date)
                    report_mismatch("result_date", want.date, got_date);
                if (got_dev !== want.dev)
                    report_mismatch("std_deviation", want.dev, got_dev);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_CYCLES) begin
                $display("Timeout: no transfer for %0d cycles, %0d results pending",
                         quiet, pending_devs.size());
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin : stimulus
        logic [LEN_W-1:0] mid_len;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        win_len_reg = 9'(WL_RESET);
        ring_wp     = '0;
        clear_window_state();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, starting from the reset window length.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_window_length(dir_rows[i].len);
            else
                send_sample(dir_rows[i].start, dir_rows[i].date, dir_rows[i].value,
                            dir_rows[i].chk, dir_rows[i].dev);
        end

        // Long stretch without idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(9'd7, 40, 2, 1'b0);
        tx_idle_pct = 9;
        rx_idle_pct = 9;
        run_phase(9'd1, 25, 5, 1'b0);
        mid_len = LEN_W'($urandom_range(12, 2));
        run_phase(mid_len, 60, 2, 1'b1);
        // Full-scale write saturates to the largest window.
        run_phase(9'h1FF, 262, 0, 1'b0);
        // Short window with frequent series restarts.
        run_phase(9'd2, 50, 30, 1'b0);

        s_tvalid <= 1'b0;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d samples and %0d deviation results over window lengths",
                 samples_sent, results_seen);
        $display("  0, 1, 2, 7, %0d, 20 (reset) and 511 (saturated); %0d mismatches.",
                 mid_len, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_devs.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
hdl/rwsd_pkg.sv
hdl/rolling_window_std_deviation_top.sv
tb/tb.sv
